// ----- sv/pls_pkg.sv -----
// Shared constants for the positional list store.
package pls_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned CmdW = 3;
  localparam int unsigned ValW = 32;
  localparam int unsigned PosW = 8;
  localparam int unsigned StatW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_REM_FRONT = 3'd3,
    CMD_REM_BACK  = 3'd4
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

endpackage

// ----- sv/pls_if.sv -----
// Handshake interfaces for the command and result channels.
interface pls_cmd_if import pls_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic        [CmdW-1:0]  command;
  logic signed [ValW-1:0]  value;
  logic        [PosW-1:0]  position;
  modport source (output valid, command, value, position, input ready);
  modport sink   (input valid, command, value, position, output ready);
endinterface

interface pls_res_if import pls_pkg::*; #(
  parameter int unsigned CntW = 5
) ();
  logic                    valid;
  logic                    ready;
  logic signed [ValW-1:0]  removed_value;
  logic        [StatW-1:0] status;
  logic        [CntW-1:0]  entry_count;
  modport source (output valid, removed_value, status, entry_count, input ready);
  modport sink   (input valid, removed_value, status, entry_count, output ready);
endinterface

// ----- sv/positional_list_store.sv -----
// Positional list store: ordered list of signed words kept in one RAM.
//
//  channel | dir | payload                                  | handshake
//  cmd_ch  | in  | command, value, position                 | valid/ready
//  res_ch  | out | removed_value, status, entry_count       | valid/ready
//
// One command at a time. Entries sit in order in a RAM with a registered read.
// Insert at index k moves count-k entries back, each by a read then a write,
// then writes the new entry and loads the result. Front removal reads the
// head and shifts the rest forward; back removal reads the tail.
// Reset clears the fill count and control state; RAM contents are not cleared.
// A stalled result holds; a new command is taken once the result is loaded.
module positional_list_store import pls_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth,
  localparam int unsigned CntW = $clog2(DEPTH + 1),
  localparam int unsigned AdrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pls_cmd_if.sink    cmd_ch,
  pls_res_if.source  res_ch
);

  localparam int unsigned CmpW = (CntW > PosW) ? CntW + 1 : PosW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_WR, S_PUT, S_FR_RD, S_FR_CAP,
    S_DN_RD, S_DN_WR, S_BK_RD, S_BK_CAP, S_DONE
  } state_e;

  state_e state_q;
  logic [CntW-1:0] count_q, ptr_q, tgt_q;
  logic signed [ValW-1:0] val_q, removed_q;
  logic [StatW-1:0] status_q;

  logic signed [ValW-1:0] mem [DEPTH];
  logic signed [ValW-1:0] rd_data_q;
  logic [AdrW-1:0] rd_addr;

  logic out_valid_q;
  logic signed [ValW-1:0] out_rem_q;
  logic [StatW-1:0] out_stat_q;
  logic [CntW-1:0] out_cnt_q;

  logic accept;
  logic res_load;
  logic [CmpW-1:0] pos_ext, cnt_ext;
  logic pos_bad, full;
  logic [CntW-1:0] ptr_dec, ptr_inc;

  assign cmd_ch.ready = (state_q == S_IDLE);
  assign accept = cmd_ch.valid && cmd_ch.ready;
  assign res_load = (state_q == S_DONE) && (!out_valid_q || res_ch.ready);
  assign pos_ext = CmpW'(cmd_ch.position);
  assign cnt_ext = CmpW'(count_q);
  assign pos_bad = (pos_ext == '0) ||
                   ((count_q == '0) ? (pos_ext != CmpW'(1)) : (pos_ext > cnt_ext));
  assign full = (count_q == CntW'(DEPTH));
  assign ptr_dec = ptr_q - CntW'(1);
  assign ptr_inc = ptr_q + CntW'(1);

  assign res_ch.valid = out_valid_q;
  assign res_ch.removed_value = out_rem_q;
  assign res_ch.status = out_stat_q;
  assign res_ch.entry_count = out_cnt_q;

  always_comb begin
    unique case (state_q)
      S_UP_RD: rd_addr = ptr_dec[AdrW-1:0];
      S_FR_RD: rd_addr = '0;
      default: rd_addr = ptr_q[AdrW-1:0];
    endcase
  end

  // RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr];
    if (state_q == S_UP_WR) begin
      mem[ptr_q[AdrW-1:0]] <= rd_data_q;
    end else if (state_q == S_DN_WR) begin
      mem[ptr_dec[AdrW-1:0]] <= rd_data_q;
    end else if (state_q == S_PUT) begin
      mem[tgt_q[AdrW-1:0]] <= val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ptr_q <= '0;
      tgt_q <= '0;
      val_q <= '0;
      removed_q <= '0;
      status_q <= ST_OK;
      out_valid_q <= 1'b0;
      out_rem_q <= '0;
      out_stat_q <= ST_OK;
      out_cnt_q <= '0;
    end else begin
      if (res_load) out_valid_q <= 1'b1;
      else if (res_ch.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            val_q <= cmd_ch.value;
            removed_q <= '0;
            unique case (cmd_ch.command)
              CMD_INS_FRONT, CMD_INS_BACK: begin
                ptr_q <= count_q;
                tgt_q <= (cmd_ch.command == CMD_INS_FRONT) ? '0 : count_q;
                status_q <= full ? ST_FULL : ST_OK;
                if (full) state_q <= S_DONE;
                else if (cmd_ch.command == CMD_INS_BACK || count_q == '0) state_q <= S_PUT;
                else state_q <= S_UP_RD;
              end
              CMD_INS_POS: begin
                ptr_q <= count_q;
                tgt_q <= CntW'(pos_ext - CmpW'(1));
                status_q <= pos_bad ? ST_RANGE : (full ? ST_FULL : ST_OK);
                if (pos_bad || full) state_q <= S_DONE;
                else if (count_q == '0) state_q <= S_PUT;
                else state_q <= S_UP_RD;
              end
              CMD_REM_FRONT: begin
                ptr_q <= count_q;
                status_q <= (count_q == '0) ? ST_EMPTY : ST_OK;
                state_q <= (count_q == '0) ? S_DONE : S_FR_RD;
              end
              CMD_REM_BACK: begin
                ptr_q <= count_q - CntW'(1);
                status_q <= (count_q == '0) ? ST_EMPTY : ST_OK;
                state_q <= (count_q == '0) ? S_DONE : S_BK_RD;
              end
              default: begin
                ptr_q <= count_q;
                status_q <= ST_OK;
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_UP_RD: state_q <= S_UP_WR;
        S_UP_WR: begin
          ptr_q <= ptr_dec;
          state_q <= (ptr_dec == tgt_q) ? S_PUT : S_UP_RD;
        end
        S_PUT: begin
          count_q <= count_q + CntW'(1);
          state_q <= S_DONE;
        end
        S_FR_RD: state_q <= S_FR_CAP;
        S_FR_CAP: begin
          removed_q <= rd_data_q;
          ptr_q <= CntW'(1);
          if (count_q == CntW'(1)) begin
            count_q <= count_q - CntW'(1);
            state_q <= S_DONE;
          end else begin
            state_q <= S_DN_RD;
          end
        end
        S_DN_RD: state_q <= S_DN_WR;
        S_DN_WR: begin
          ptr_q <= ptr_inc;
          if (ptr_inc == count_q) begin
            count_q <= count_q - CntW'(1);
            state_q <= S_DONE;
          end else begin
            state_q <= S_DN_RD;
          end
        end
        S_BK_RD: state_q <= S_BK_CAP;
        S_BK_CAP: begin
          removed_q <= rd_data_q;
          count_q <= count_q - CntW'(1);
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (res_load) begin
            out_rem_q <= removed_q;
            out_stat_q <= status_q;
            out_cnt_q <= count_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/pls_chk.sv -----
// Port-level checks for the positional list store, bound to the top level.
module pls_chk import pls_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth,
  parameter int unsigned CntW = 5
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   res_valid_i,
  input logic                   res_ready_i,
  input logic signed [ValW-1:0] removed_value_i,
  input logic [StatW-1:0]       status_i,
  input logic [CntW-1:0]        entry_count_i
);

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> entry_count_i <= CntW'(DEPTH))
    else $error("entry count beyond depth");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && status_i != ST_OK) |-> removed_value_i == '0)
    else $error("rejected transaction carries a removed value");

  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && status_i == ST_FULL) |-> entry_count_i == CntW'(DEPTH))
    else $error("full status with list not full");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> res_valid_i && $stable(entry_count_i) &&
                                      $stable(status_i) && $stable(removed_value_i))
    else $error("stalled result changed");

endmodule

bind positional_list_store pls_chk #(.DEPTH(DEPTH), .CntW(CntW)) u_pls_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid_i     (res_ch.valid),
  .res_ready_i     (res_ch.ready),
  .removed_value_i (res_ch.removed_value),
  .status_i        (res_ch.status),
  .entry_count_i   (res_ch.entry_count)
);

// ----- test/tb_positional_list_store.sv -----
// Testbench for the positional list store: directed and random commands, self-checked.
`timescale 1ns / 100ps

module tb_positional_list_store;
  import pls_pkg::*;

  localparam int unsigned Depth = DefaultDepth;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic signed [ValW-1:0] removed_value;
    status_e                status;
    logic [CntW-1:0]        entry_count;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pls_cmd_if cmd_ch ();
  pls_res_if #(.CntW(CntW)) res_ch ();

  positional_list_store #(.DEPTH(Depth)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_ch (cmd_ch),
    .res_ch (res_ch)
  );

  always #6 clk_i = ~clk_i;

  // Model state
  logic signed [ValW-1:0] shadow_list [Depth];
  int unsigned shadow_count;
  res_t expected_res_q [$];
  int unsigned error_cnt = 0;
  int unsigned idle_cycles = 0;

  function automatic int unsigned rand_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Apply one command to the shadow list and queue its result.
  task automatic predict_list_op(logic [CmdW-1:0] cmd, logic signed [ValW-1:0] val,
                                 logic [PosW-1:0] pos);
    res_t r;
    int unsigned idx;
    r.removed_value = '0;
    r.status = ST_OK;
    idx = Depth;
    case (cmd)
      CMD_INS_FRONT: begin
        if (shadow_count >= Depth) r.status = ST_FULL;
        else idx = 0;
      end
      CMD_INS_BACK: begin
        if (shadow_count >= Depth) r.status = ST_FULL;
        else idx = shadow_count;
      end
      CMD_INS_POS: begin
        if (pos == 0 || (shadow_count == 0 ? pos != 1 : pos > shadow_count))
          r.status = ST_RANGE;
        else if (shadow_count >= Depth) r.status = ST_FULL;
        else idx = pos - 1;
      end
      CMD_REM_FRONT: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else begin
          r.removed_value = shadow_list[0];
          for (int i = 1; i < shadow_count; i++) shadow_list[i-1] = shadow_list[i];
          shadow_count--;
        end
      end
      CMD_REM_BACK: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else begin
          r.removed_value = shadow_list[shadow_count-1];
          shadow_count--;
        end
      end
      default: ;
    endcase
    if (idx < Depth) begin
      for (int i = shadow_count; i > idx; i--) shadow_list[i] = shadow_list[i-1];
      shadow_list[idx] = val;
      shadow_count++;
    end
    r.entry_count = CntW'(shadow_count);
    expected_res_q.push_back(r);
  endtask

  // Valid stays high after a transaction until the next gap or the end of the run
  task automatic send_cmd(logic [CmdW-1:0] cmd, logic signed [ValW-1:0] val,
                          logic [PosW-1:0] pos);
    int unsigned gap;
    gap = rand_gap();
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.command  <= cmd;
    cmd_ch.value    <= val;
    cmd_ch.position <= pos;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    predict_list_op(cmd, val, pos);
  endtask

  // Result receiver with random stalls
  initial begin
    int unsigned gap;
    res_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      gap = rand_gap();
      if (gap != 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_res_q.size() == 0) begin
        $display("%0t: unexpected result rem=%0d st=%0d cnt=%0d", $time,
                 res_ch.removed_value, res_ch.status, res_ch.entry_count);
        error_cnt++;
      end else begin
        exp_r = expected_res_q.pop_front();
        if (res_ch.removed_value !== exp_r.removed_value) begin
          $display("%0t: removed_value expected %0d actual %0d", $time,
                   exp_r.removed_value, res_ch.removed_value);
          error_cnt++;
        end
        if (res_ch.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                   res_ch.status);
          error_cnt++;
        end
        if (res_ch.entry_count !== exp_r.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time,
                   exp_r.entry_count, res_ch.entry_count);
          error_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk_i) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic test_empty_list();
    send_cmd(CMD_REM_FRONT, 32'sd5, 8'd0);
    send_cmd(CMD_REM_BACK, 32'sd5, 8'd0);
    send_cmd(CMD_INS_POS, 32'sd1, 8'd0);
    send_cmd(CMD_INS_POS, 32'sd1, 8'd2);
    send_cmd(CMD_INS_POS, 32'h7fffffff, 8'd1);
    send_cmd(CMD_REM_BACK, '0, 8'hff);
  endtask

  task automatic test_fill_and_full();
    send_cmd(CMD_INS_FRONT, 32'sh80000000, 8'd0);
    send_cmd(CMD_INS_BACK, 32'sh7fffffff, 8'd0);
    for (int i = 0; i < Depth - 2; i++) send_cmd(CMD_INS_POS, $urandom, 8'(2 + i % 2));
    send_cmd(CMD_INS_FRONT, 32'sd1, 8'd0);
    send_cmd(CMD_INS_BACK, 32'sd1, 8'd0);
    send_cmd(CMD_INS_POS, 32'sd1, 8'd3);
    send_cmd(CMD_INS_POS, 32'sd1, 8'd17);
    send_cmd(CMD_INS_POS, 32'sd1, 8'hff);
    send_cmd(3'd5, 32'sd1, 8'd1);
    send_cmd(3'd7, 32'sd1, 8'd1);
  endtask

  task automatic test_drain();
    while (shadow_count > 0)
      send_cmd($urandom_range(0, 1) ? CMD_REM_FRONT : CMD_REM_BACK, $urandom,
               PosW'($urandom));
  endtask

  task automatic test_random_ops(int unsigned n_items);
    logic [CmdW-1:0] cmd;
    logic [PosW-1:0] pos;
    int unsigned bias;
    for (int k = 0; k < n_items; k++) begin
      // Drift between filling and draining phases
      bias = ((k / 150) % 2 == 0) ? 7 : 3;
      if ($urandom_range(0, 29) == 0) cmd = CmdW'($urandom_range(5, 7));
      else if ($urandom_range(0, 9) < bias) cmd = CmdW'($urandom_range(0, 2));
      else cmd = CmdW'($urandom_range(3, 4));
      case ($urandom_range(0, 5))
        0: pos = PosW'($urandom);
        1: pos = 8'd0;
        default: pos = 8'($urandom_range(1, shadow_count + 1));
      endcase
      send_cmd(cmd, $urandom, pos);
    end
  endtask

  initial begin
    shadow_count = 0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.command <= '0;
    cmd_ch.value <= '0;
    cmd_ch.position <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_fill_and_full();
    test_drain();
    test_random_ops(1040);
    test_drain();
    cmd_ch.valid <= 1'b0;
    while (expected_res_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_cnt == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
